// ===== rtl/xtrk_pkg.sv =====
package xtrk_pkg;

  localparam int SampleWidthDef = 16;
  localparam int DeltaWidth     = 15;
  localparam int TickWidth      = 16;
  localparam int CfgIdxWidth    = 2;

  localparam logic [DeltaWidth-1:0] DeltaReset  = 15'd50;
  localparam logic [TickWidth-1:0]  SettleReset = 16'd3600;

  localparam logic [CfgIdxWidth-1:0] CFG_DELTA      = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_SETTLE     = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_STORED_MIN = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_STORED_MAX = 2'd3;

  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_TICK   = 2'd1,
    FUNC_INIT   = 2'd2
  } func_t;

  typedef struct packed {
    logic attempt;
    logic done;
    logic pending;
  } xtrk_flags_t;

endpackage

// ===== rtl/xtrk_cfg.sv =====
module xtrk_cfg
  import xtrk_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SampleWidthDef,
  parameter int CFG_WIDTH    = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [CfgIdxWidth-1:0]         cfg_index,
  input  logic [CFG_WIDTH-1:0]           cfg_wdata,
  output logic [DeltaWidth-1:0]          delta,
  output logic [TickWidth-1:0]           settle,
  output logic signed [SAMPLE_WIDTH-1:0] stored_min,
  output logic signed [SAMPLE_WIDTH-1:0] stored_max
);

  logic [DeltaWidth-1:0]          delta_r;
  logic [TickWidth-1:0]           settle_r;
  logic signed [SAMPLE_WIDTH-1:0] smin_r;
  logic signed [SAMPLE_WIDTH-1:0] smax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_r  <= DeltaReset;
      settle_r <= SettleReset;
      smin_r   <= '0;
      smax_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DELTA:      delta_r  <= cfg_wdata[DeltaWidth-1:0];
        CFG_SETTLE:     settle_r <= cfg_wdata[TickWidth-1:0];
        CFG_STORED_MIN: smin_r   <= cfg_wdata[SAMPLE_WIDTH-1:0];
        CFG_STORED_MAX: smax_r   <= cfg_wdata[SAMPLE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign delta      = delta_r;
  assign settle     = settle_r;
  assign stored_min = smin_r;
  assign stored_max = smax_r;

endmodule

// ===== rtl/xtrk_core.sv =====
module xtrk_core
  import xtrk_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SampleWidthDef
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic [1:0]                     func,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           flash_ready,
  input  logic [DeltaWidth-1:0]          delta,
  input  logic [TickWidth-1:0]           settle,
  input  logic signed [SAMPLE_WIDTH-1:0] stored_min,
  input  logic signed [SAMPLE_WIDTH-1:0] stored_max,
  output xtrk_flags_t                    flags,
  output logic signed [SAMPLE_WIDTH-1:0] save_min,
  output logic signed [SAMPLE_WIDTH-1:0] save_max
);

  localparam int DW = ((SAMPLE_WIDTH + 1 > DeltaWidth + 1) ? SAMPLE_WIDTH + 1
                                                           : DeltaWidth + 1) + 1;

  logic signed [SAMPLE_WIDTH-1:0] rmin_r, rmin_nxt;
  logic signed [SAMPLE_WIDTH-1:0] rmax_r, rmax_nxt;
  logic signed [SAMPLE_WIDTH-1:0] cmin_r, cmin_nxt;
  logic signed [SAMPLE_WIDTH-1:0] cmax_r, cmax_nxt;
  logic [TickWidth-1:0]           cnt_r, cnt_nxt;
  logic                           pend_r, pend_nxt;

  logic signed [SAMPLE_WIDTH-1:0] new_min, new_max;
  logic                           lower, higher;
  logic signed [DW-1:0]           dmin, dmax, sig_x;
  logic                           force_commit;
  logic [TickWidth-1:0]           cnt_inc;
  logic                           attempt, done;

  assign lower   = sample < rmin_r;
  assign higher  = sample > rmax_r;
  assign new_min = lower  ? sample : rmin_r;
  assign new_max = higher ? sample : rmax_r;
  assign dmin    = DW'(cmin_r) - DW'(new_min);
  assign dmax    = DW'(new_max) - DW'(cmax_r);
  assign sig_x   = $signed(DW'(delta));
  assign force_commit = (dmin >= sig_x) || (dmax >= sig_x);
  assign cnt_inc = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;

  always_comb begin
    rmin_nxt = rmin_r;
    rmax_nxt = rmax_r;
    cmin_nxt = cmin_r;
    cmax_nxt = cmax_r;
    cnt_nxt  = cnt_r;
    pend_nxt = pend_r;
    attempt  = 1'b0;
    done     = 1'b0;
    unique case (func_t'(func))
      FUNC_SAMPLE: begin
        rmin_nxt = new_min;
        rmax_nxt = new_max;
        if (lower || higher) begin
          cnt_nxt  = '0;
          pend_nxt = 1'b1;
          if (force_commit) begin
            attempt = 1'b1;
            if (flash_ready) begin
              done     = 1'b1;
              cmin_nxt = new_min;
              cmax_nxt = new_max;
              pend_nxt = 1'b0;
            end
          end
        end
      end
      FUNC_TICK: begin
        if (pend_r) begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= settle) begin
            attempt = 1'b1;
            if (flash_ready) begin
              done     = 1'b1;
              cmin_nxt = rmin_r;
              cmax_nxt = rmax_r;
              pend_nxt = 1'b0;
            end else begin
              cnt_nxt = (settle == '0) ? '0 : settle - 1'b1;
            end
          end
        end
      end
      FUNC_INIT: begin
        rmin_nxt = stored_min;
        rmax_nxt = stored_max;
        cmin_nxt = stored_min;
        cmax_nxt = stored_max;
        cnt_nxt  = '0;
        pend_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rmin_r <= '0;
      rmax_r <= '0;
      cmin_r <= '0;
      cmax_r <= '0;
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else if (step) begin
      rmin_r <= rmin_nxt;
      rmax_r <= rmax_nxt;
      cmin_r <= cmin_nxt;
      cmax_r <= cmax_nxt;
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
    end
  end

  assign flags.attempt = attempt;
  assign flags.done    = done;
  assign flags.pending = pend_nxt;
  assign save_min      = attempt ? rmin_nxt : '0;
  assign save_max      = attempt ? rmax_nxt : '0;

`ifndef NO_ASSERTIONS
  a_init_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && func == FUNC_INIT |=> !pend_r && cnt_r == '0 && cmin_r == rmin_r)
    else $error("init did not reload the tracker state");
  a_running_order: assert property (@(posedge clk) disable iff (!rst_n)
    $past(step) && $past(func) == FUNC_SAMPLE && $past(rmin_r <= rmax_r)
    |-> rmin_r <= rmax_r)
    else $error("running extremes crossed after a sample");
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(cnt_r) && $stable(pend_r))
    else $error("tracker state moved without an item");
`endif

endmodule

// ===== rtl/extremes_tracker_commit_debounce.sv =====
// Tracks the running minimum and maximum of signed temperature samples and
// decides when to commit them to external storage. Each item is a sample, a
// one-second tick or an init that reloads all extremes from the stored_min and
// stored_max registers. Each accepted item yields exactly one result, and a new
// item is accepted every cycle while out_ready is high: one input register and
// one result register bound a single compare, subtract and select stage.
// Configuration registers must be written only while idle; this is unenforced.
module extremes_tracker_commit_debounce
  import xtrk_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SampleWidthDef
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_func,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_flash_ready,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_commit_attempt,
  output logic                           out_commit_done,
  output logic signed [SAMPLE_WIDTH-1:0] out_save_min,
  output logic signed [SAMPLE_WIDTH-1:0] out_save_max,
  output logic                           out_pending,
  input  logic                           cfg_we,
  input  logic [CfgIdxWidth-1:0]         cfg_index,
  input  logic [((SAMPLE_WIDTH > TickWidth) ? SAMPLE_WIDTH : TickWidth)-1:0] cfg_wdata
);

  localparam int CfgWidth = (SAMPLE_WIDTH > TickWidth) ? SAMPLE_WIDTH : TickWidth;

  logic                           in_vld_r;
  logic [1:0]                     func_r;
  logic signed [SAMPLE_WIDTH-1:0] sample_r;
  logic                           fready_r;
  logic                           out_vld_r;
  xtrk_flags_t                    flags_r;
  logic signed [SAMPLE_WIDTH-1:0] smin_r, smax_r;

  logic                           advance;
  xtrk_flags_t                    flags;
  logic signed [SAMPLE_WIDTH-1:0] save_min, save_max;
  logic [DeltaWidth-1:0]          delta;
  logic [TickWidth-1:0]           settle;
  logic signed [SAMPLE_WIDTH-1:0] stored_min, stored_max;

  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  xtrk_cfg #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .CFG_WIDTH    (CfgWidth)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .delta      (delta),
    .settle     (settle),
    .stored_min (stored_min),
    .stored_max (stored_max)
  );

  xtrk_core #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .func        (func_r),
    .sample      (sample_r),
    .flash_ready (fready_r),
    .delta       (delta),
    .settle      (settle),
    .stored_min  (stored_min),
    .stored_max  (stored_max),
    .flags       (flags),
    .save_min    (save_min),
    .save_max    (save_max)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r   <= in_func;
      sample_r <= in_sample;
      fready_r <= in_flash_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      flags_r <= flags;
      smin_r  <= save_min;
      smax_r  <= save_max;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_commit_attempt = flags_r.attempt;
  assign out_commit_done    = flags_r.done;
  assign out_pending        = flags_r.pending;
  assign out_save_min       = smin_r;
  assign out_save_max       = smax_r;

`ifndef NO_ASSERTIONS
  a_done_needs_attempt: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(flags_r.done && !flags_r.attempt))
    else $error("commit reported done without an attempt");
  a_done_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && flags_r.done |-> !flags_r.pending)
    else $error("pending still set after an accepted commit");
  a_quiet_save: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !flags_r.attempt |-> smin_r == '0 && smax_r == '0)
    else $error("save values shown without an attempt");
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ready |=> out_vld_r && $stable(flags_r) && $stable(smin_r)
    && $stable(smax_r))
    else $error("stalled result was overwritten");
`endif

endmodule
